>>> rtl/lpe_pkg.sv
// Package for the line position estimator: widths, reset values, codes,
// the fixed sensor weights and the job record passed from front to back.
// Depends on nothing; every other file imports it.
package lpe_pkg;

   localparam int LPE_SENSOR_COUNT = 6;
   localparam int LPE_SAMPLE_BITS  = 10;

   localparam int LPE_THR_BITS   = 10;
   localparam int LPE_CROSS_BITS = 3;
   localparam logic [LPE_THR_BITS-1:0]   LPE_THR_RESET   = 10'd512;
   localparam logic [LPE_CROSS_BITS-1:0] LPE_CROSS_RESET = 3'd5;

   localparam int LPE_CSR_INDEX_BITS = 2;
   localparam int LPE_CSR_DATA_BITS  = 10;
   localparam logic [LPE_CSR_INDEX_BITS-1:0] LPE_CSR_LINE_THRESHOLD   = 2'd0;
   localparam logic [LPE_CSR_INDEX_BITS-1:0] LPE_CSR_CROSS_MIN_ACTIVE = 2'd1;

   localparam int LPE_INTEN_BITS = LPE_THR_BITS;
   localparam int LPE_COUNT_BITS = 3;
   localparam int LPE_TSUM_BITS  = 13;
   localparam int LPE_WSUM_BITS  = 15;
   localparam int LPE_MAG_BITS   = 14;
   localparam int LPE_DIV_BITS   = 15;
   localparam int LPE_CMP_BITS   = 17;
   localparam int LPE_FRAC_BITS  = 10;
   localparam int LPE_QUO_BITS   = LPE_FRAC_BITS + 1;
   localparam int LPE_POS_BITS   = 12;
   localparam logic [LPE_QUO_BITS-1:0] LPE_POS_ONE = LPE_QUO_BITS'(1 << LPE_FRAC_BITS);

   localparam int LPE_QUEUE_DEPTH = 2;

   localparam logic signed [3:0] LPE_WEIGHTS [LPE_SENSOR_COUNT] =
      '{-4'sd5, -4'sd3, -4'sd1, 4'sd1, 4'sd3, 4'sd5};

   typedef enum logic [2:0] {
      LPE_PAT_LOST         = 3'd0,
      LPE_PAT_INTERSECTION = 3'd1,
      LPE_PAT_STRAIGHT     = 3'd2,
      LPE_PAT_LIGHT        = 3'd3,
      LPE_PAT_MEDIUM       = 3'd4,
      LPE_PAT_SHARP        = 3'd5
   } pattern_type;

   typedef enum logic [1:0] {
      LPE_DIR_CENTER = 2'd0,
      LPE_DIR_LEFT   = 2'd1,
      LPE_DIR_RIGHT  = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      LPE_BACK_IDLE = 2'd0,
      LPE_BACK_PREP = 2'd1,
      LPE_BACK_DIV  = 2'd2,
      LPE_BACK_DONE = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [LPE_SENSOR_COUNT-1:0]     mask;
      logic [LPE_COUNT_BITS-1:0]       count;
      logic signed [LPE_WSUM_BITS-1:0] wsum;
      logic [LPE_TSUM_BITS-1:0]        tsum;
      logic                            cross_hit;
   } job_type;

endpackage

>>> rtl/lpe_front.sv
// Front of the line position estimator: configuration registers, sample
// classification and the weighted and plain intensity sums of one beat.
// Depends on lpe_pkg.
module lpe_front import lpe_pkg::*; #(
   parameter int SAMPLE_BITS = LPE_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [SAMPLE_BITS-1:0]        req_sample_0,
   input  logic [SAMPLE_BITS-1:0]        req_sample_1,
   input  logic [SAMPLE_BITS-1:0]        req_sample_2,
   input  logic [SAMPLE_BITS-1:0]        req_sample_3,
   input  logic [SAMPLE_BITS-1:0]        req_sample_4,
   input  logic [SAMPLE_BITS-1:0]        req_sample_5,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [LPE_CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LPE_CSR_DATA_BITS-1:0]  csr_data,
   output logic                          q_push,
   input  logic                          q_full,
   output job_type                       job
);

   localparam int CMP_W = (SAMPLE_BITS > LPE_THR_BITS) ? SAMPLE_BITS : LPE_THR_BITS;

   logic [LPE_THR_BITS-1:0]   thr_ff;
   logic [LPE_CROSS_BITS-1:0] cross_ff;
   logic [SAMPLE_BITS-1:0]    samples [LPE_SENSOR_COUNT];

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign q_push    = push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= LPE_THR_RESET;
         cross_ff <= LPE_CROSS_RESET;
      end else if (csr_valid) begin
         priority if (csr_index == LPE_CSR_LINE_THRESHOLD) begin
            thr_ff <= csr_data[LPE_THR_BITS-1:0];
         end else if (csr_index == LPE_CSR_CROSS_MIN_ACTIVE) begin
            cross_ff <= csr_data[LPE_CROSS_BITS-1:0];
         end else begin
            thr_ff <= thr_ff;
         end
      end
   end

   always_comb begin
      logic [LPE_INTEN_BITS-1:0]       diff;
      logic [LPE_INTEN_BITS-1:0]       inten;
      logic signed [LPE_WSUM_BITS-1:0] wt;
      logic signed [LPE_WSUM_BITS-1:0] iv;
      job = '0;
      for (int i = 0; i < LPE_SENSOR_COUNT; i++) begin
         diff  = thr_ff - LPE_INTEN_BITS'(samples[i]);
         inten = (diff == '0) ? LPE_INTEN_BITS'(1) : diff;
         wt    = LPE_WSUM_BITS'(LPE_WEIGHTS[i]);
         iv    = signed'(LPE_WSUM_BITS'(inten));
         if (CMP_W'(samples[i]) <= CMP_W'(thr_ff)) begin
            job.mask[i] = 1'b1;
            job.count   = job.count + 1'b1;
            job.wsum    = job.wsum + wt * iv;
            job.tsum    = job.tsum + LPE_TSUM_BITS'(inten);
         end
      end
      job.cross_hit = (job.count >= cross_ff);
   end

endmodule

>>> rtl/lpe_queue.sv
// Short job queue between the front and the back of the estimator.
// Depends on lpe_pkg for the job record and the depth.
module lpe_queue import lpe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output job_type rd_data,
   output logic    empty
);

   localparam int PTR_BITS = (LPE_QUEUE_DEPTH > 1) ? $clog2(LPE_QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(LPE_QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(LPE_QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(LPE_QUEUE_DEPTH);

   job_type             entries_ff [LPE_QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_wr;
   logic                do_rd;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/lpe_back.sv
// Back of the estimator: pattern and direction decisions, the bit-serial
// position divider, the stored last direction and the result register.
// Depends on lpe_pkg.
module lpe_back import lpe_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  job_type                        job,
   input  logic                           pop,
   output logic                           empty,
   output logic [LPE_SENSOR_COUNT-1:0]    rsp_active_mask,
   output logic [LPE_COUNT_BITS-1:0]      rsp_active_count,
   output logic signed [LPE_POS_BITS-1:0] rsp_line_position,
   output logic [2:0]                     rsp_line_pattern,
   output logic [1:0]                     rsp_heading_side
);

   localparam int STEP_BITS = $clog2(LPE_FRAC_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(LPE_FRAC_BITS - 1);

   back_state_type state_ff;
   back_state_type state_in;

   job_type                   job_ff;
   logic [LPE_DIV_BITS-1:0]   div_ff;
   logic [LPE_DIV_BITS-1:0]   rem_ff;
   logic [LPE_QUO_BITS-1:0]   quo_ff;
   logic [STEP_BITS-1:0]      step_ff;
   logic                      neg_ff;
   pattern_type               pattern_ff;
   dir_type                   last_dir_ff;
   logic                      out_valid_ff;
   logic                      finish;

   logic [LPE_MAG_BITS-1:0]          mag;
   logic [LPE_DIV_BITS-1:0]          d5;
   logic [LPE_CMP_BITS-1:0]          m4;
   logic [LPE_CMP_BITS-1:0]          m2;
   logic [LPE_CMP_BITS-1:0]          t5;
   logic [LPE_CMP_BITS-1:0]          t15;
   logic signed [LPE_CMP_BITS-1:0]   sx;
   logic signed [LPE_CMP_BITS-1:0]   tx;
   logic                             is_neg;
   pattern_type                      pattern;
   dir_type                          new_dir;
   logic [LPE_DIV_BITS:0]            r2;
   logic [LPE_POS_BITS-1:0]          qpos;

   always_comb begin
      is_neg = job_ff.wsum < 0;
      mag    = is_neg ? LPE_MAG_BITS'(-job_ff.wsum) : LPE_MAG_BITS'(job_ff.wsum);
      d5     = LPE_DIV_BITS'({job_ff.tsum, 2'b00}) + LPE_DIV_BITS'(job_ff.tsum);
      m4     = LPE_CMP_BITS'({mag, 2'b00});
      m2     = LPE_CMP_BITS'({mag, 1'b0});
      t5     = LPE_CMP_BITS'(d5);
      t15    = LPE_CMP_BITS'({job_ff.tsum, 4'b0000}) - LPE_CMP_BITS'(job_ff.tsum);
      sx     = LPE_CMP_BITS'(job_ff.wsum);
      tx     = signed'(LPE_CMP_BITS'(job_ff.tsum));
      priority if (sx + sx + tx < 0) begin
         new_dir = LPE_DIR_LEFT;
      end else if (sx + sx - tx > 0) begin
         new_dir = LPE_DIR_RIGHT;
      end else begin
         new_dir = LPE_DIR_CENTER;
      end
      priority if (job_ff.cross_hit) begin
         pattern = LPE_PAT_INTERSECTION;
      end else if (m4 < t5) begin
         pattern = LPE_PAT_STRAIGHT;
      end else if (m2 < t5) begin
         pattern = LPE_PAT_LIGHT;
      end else if (m4 < t15) begin
         pattern = LPE_PAT_MEDIUM;
      end else begin
         pattern = LPE_PAT_SHARP;
      end
      r2   = {rem_ff, 1'b0};
      qpos = LPE_POS_BITS'(quo_ff);
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         LPE_BACK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = LPE_BACK_PREP;
            end
         end
         LPE_BACK_PREP: begin
            if (job_ff.count == '0 || mag >= d5) begin
               state_in = LPE_BACK_DONE;
            end else begin
               state_in = LPE_BACK_DIV;
            end
         end
         LPE_BACK_DIV: begin
            if (step_ff == LAST_STEP) begin
               state_in = LPE_BACK_DONE;
            end
         end
         LPE_BACK_DONE: begin
            if (!out_valid_ff || pop) begin
               finish   = 1'b1;
               state_in = LPE_BACK_IDLE;
            end
         end
         default: state_in = LPE_BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LPE_BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= job;
      end
      if (state_ff == LPE_BACK_PREP) begin
         div_ff  <= d5;
         rem_ff  <= LPE_DIV_BITS'(mag);
         step_ff <= '0;
         if (job_ff.count == '0) begin
            pattern_ff <= LPE_PAT_LOST;
            neg_ff     <= (last_dir_ff == LPE_DIR_LEFT);
            quo_ff     <= (last_dir_ff == LPE_DIR_LEFT || last_dir_ff == LPE_DIR_RIGHT)
                          ? LPE_POS_ONE : '0;
         end else begin
            pattern_ff <= pattern;
            neg_ff     <= is_neg;
            quo_ff     <= (mag >= d5) ? LPE_POS_ONE : '0;
         end
      end
      if (state_ff == LPE_BACK_DIV) begin
         step_ff <= step_ff + 1'b1;
         if (r2 >= {1'b0, div_ff}) begin
            rem_ff <= LPE_DIV_BITS'(r2 - {1'b0, div_ff});
            quo_ff <= {quo_ff[LPE_QUO_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= r2[LPE_DIV_BITS-1:0];
            quo_ff <= {quo_ff[LPE_QUO_BITS-2:0], 1'b0};
         end
      end
      if (finish) begin
         rsp_active_mask   <= job_ff.mask;
         rsp_active_count  <= job_ff.count;
         rsp_line_position <= neg_ff ? -signed'(qpos) : signed'(qpos);
         rsp_line_pattern  <= pattern_ff;
         rsp_heading_side  <= last_dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff  <= LPE_DIR_CENTER;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == LPE_BACK_PREP && job_ff.count != '0) begin
            last_dir_ff <= new_dir;
         end
         out_valid_ff <= finish || (out_valid_ff && !pop);
      end
   end

   assign empty = !out_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == LPE_BACK_DIV |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == LPE_BACK_IDLE && !q_empty |=> state_ff == LPE_BACK_PREP)
      else $error("queued job not taken up");

   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_line_pattern == LPE_PAT_LOST |-> rsp_active_count == '0)
      else $error("lost pattern with active sensors");

   assert property (@(posedge clock) disable iff (reset)
      finish |=> !empty)
      else $error("finished result not presented");

endmodule

>>> rtl/line_position_estimator_unit.sv
// Line position estimator top level. An accepted beat goes through the
// queue and the back's prepare state, ten-step bit-serial divider and done
// state into the result register; the divider is skipped when no sample
// is active or the position clamps. The back handles one beat at a time.
// Synchronous reset clears the queue and result, sets the threshold to 512,
// the intersection count to 5 and the last direction to center.
module line_position_estimator_unit import lpe_pkg::*; #(
   parameter int SAMPLE_BITS = LPE_SAMPLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [SAMPLE_BITS-1:0]         req_sample_0,
   input  logic [SAMPLE_BITS-1:0]         req_sample_1,
   input  logic [SAMPLE_BITS-1:0]         req_sample_2,
   input  logic [SAMPLE_BITS-1:0]         req_sample_3,
   input  logic [SAMPLE_BITS-1:0]         req_sample_4,
   input  logic [SAMPLE_BITS-1:0]         req_sample_5,
   output logic                           empty,
   input  logic                           pop,
   output logic [LPE_SENSOR_COUNT-1:0]    rsp_active_mask,
   output logic [LPE_COUNT_BITS-1:0]      rsp_active_count,
   output logic signed [LPE_POS_BITS-1:0] rsp_line_position,
   output logic [2:0]                     rsp_line_pattern,
   output logic [1:0]                     rsp_heading_side,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [LPE_CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [LPE_CSR_DATA_BITS-1:0]   csr_data
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   job_type q_wr_job;
   job_type q_rd_job;

   lpe_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_sample_0 (req_sample_0),
      .req_sample_1 (req_sample_1),
      .req_sample_2 (req_sample_2),
      .req_sample_3 (req_sample_3),
      .req_sample_4 (req_sample_4),
      .req_sample_5 (req_sample_5),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_push       (q_push),
      .q_full       (q_full),
      .job          (q_wr_job)
   );

   lpe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_job),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_job),
      .empty   (q_empty)
   );

   lpe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .job               (q_rd_job),
      .pop               (pop),
      .empty             (empty),
      .rsp_active_mask   (rsp_active_mask),
      .rsp_active_count  (rsp_active_count),
      .rsp_line_position (rsp_line_position),
      .rsp_line_pattern  (rsp_line_pattern),
      .rsp_heading_side  (rsp_heading_side)
   );

endmodule
